// ----- src/csort_pkg.sv -----
// csort_pkg: item types, register map and status codes for the counting sort block.
// No dependencies; used by counting_sort_top.
package csort_pkg;

    localparam int VALUE_W  = 16;
    localparam int SPREAD_W = 10;
    localparam int STATUS_W = 2;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 3;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_MAX_SPREAD = '0;
    localparam logic [SPREAD_W-1:0]  SPREAD_RESET   = 10'd1023;

    localparam logic [STATUS_W-1:0] STATUS_SORTED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_WIDE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic [STATUS_W-1:0]       status;
        logic                      end_of_set;
    } out_item_t;

endpackage

// ----- src/counting_sort_top.sv -----
// counting_sort_top: loads a set of signed values, counting-sorts them through a count
// memory and emits them ascending. Depends on csort_pkg (item types, status codes).
//
//   channel   direction   handshake                  payload
//   in        input       in_valid / in_stall        csort_pkg::in_item_t
//   out       output      out_valid / out_stall      csort_pkg::out_item_t
//   cfg       input       psel, penable, pwrite      paddr, pwdata, prdata
//
// Loading takes one item per cycle; n stored items, spread s (max - min).
// After the last item: a check step, then the histogram, prefix, placement and clear
// steps, which all work through the count memory.
// A set too wide skips those steps and leaves in load order. Results leave one per cycle
// while out_stall is low. After reset the count memory is swept with in_stall high.
// A stalled result holds in the output register while the next set loads.
module counting_sort_top #(
    parameter int MAX_ITEMS  = 64,
    parameter int SPAN_DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  csort_pkg::in_item_t                   in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output csort_pkg::out_item_t                  out_data,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [csort_pkg::PADDR_W-1:0]         paddr,
    input  logic [csort_pkg::PDATA_W-1:0]         pwdata,
    output logic [csort_pkg::PDATA_W-1:0]         prdata,
    output logic                                  pready
);

    localparam int VW     = csort_pkg::VALUE_W;
    localparam int ITEM_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int SPAN_W = $clog2(SPAN_DEPTH);
    localparam int DIFF_W = VW + 1;
    localparam int CMP_A  = (VW > csort_pkg::SPREAD_W) ? VW : csort_pkg::SPREAD_W;
    localparam int CMP_W  = (CMP_A > SPAN_W + 1) ? CMP_A : SPAN_W + 1;

    typedef enum logic [3:0] {
        S_CLR_INIT,
        S_LOAD,
        S_CHECK,
        S_H_RD,
        S_H_CNT,
        S_H_WR,
        S_PREFIX,
        S_W_RD,
        S_W_CNT,
        S_W_WR,
        S_CLR_SET,
        S_EMIT
    } state_t;

    state_t                              state_reg;
    logic [csort_pkg::SPREAD_W-1:0]      max_spread_reg;
    logic [CNT_W-1:0]                    item_count_reg;
    logic signed [VW-1:0]                min_reg;
    logic signed [VW-1:0]                max_reg;
    logic                                overflow_reg;
    logic [ITEM_W-1:0]                   idx_reg;
    logic [SPAN_W-1:0]                   span_idx_reg;
    logic [SPAN_W-1:0]                   spread_slot_reg;
    logic [SPAN_W-1:0]                   slot_reg;
    logic [SPAN_W-1:0]                   wr_slot_reg;
    logic [CNT_W-1:0]                    sum_reg;
    logic                                pend_reg;
    logic                                pfx_more_reg;
    logic [csort_pkg::STATUS_W-1:0]      status_reg;
    logic                                wide_reg;
    logic                                out_valid_reg;
    logic [csort_pkg::STATUS_W-1:0]      out_status_reg;
    logic                                out_end_reg;
    logic                                out_wide_reg;

    logic [VW-1:0]                       ib_mem [MAX_ITEMS];
    logic [VW-1:0]                       sb_mem [MAX_ITEMS];
    logic [CNT_W-1:0]                    cnt_mem [SPAN_DEPTH];
    logic [VW-1:0]                       ib_rd_reg;
    logic [VW-1:0]                       ib_emit_reg;
    logic [VW-1:0]                       sb_emit_reg;
    logic [CNT_W-1:0]                    cnt_rd_reg;

    logic                                accept;
    logic                                room;
    logic [DIFF_W-1:0]                   spread_diff;
    logic [VW-1:0]                       spread;
    logic                                too_wide;
    logic [DIFF_W-1:0]                   item_diff;
    logic [SPAN_W-1:0]                   item_slot;
    logic                                idx_is_last;
    logic                                emit_en;
    logic [CNT_W-1:0]                    pos;
    logic [CNT_W-1:0]                    pfx_sum;
    logic                                ib_we;
    logic                                ib_re;
    logic                                sb_we;
    logic                                cnt_we;
    logic                                cnt_re;
    logic [SPAN_W-1:0]                   cnt_waddr;
    logic [SPAN_W-1:0]                   cnt_raddr;
    logic [CNT_W-1:0]                    cnt_wdata;
    logic                                cfg_write;

    assign in_stall  = (state_reg != S_LOAD);
    assign accept    = in_valid && !in_stall;
    assign room      = item_count_reg < CNT_W'(MAX_ITEMS);

    assign spread_diff = {max_reg[VW-1], max_reg} - {min_reg[VW-1], min_reg};
    assign spread      = spread_diff[VW-1:0];
    assign too_wide    = (CMP_W'(spread) > CMP_W'(max_spread_reg))
                      || (CMP_W'(spread) >= CMP_W'(SPAN_DEPTH));

    assign item_diff   = {ib_rd_reg[VW-1], ib_rd_reg} - {min_reg[VW-1], min_reg};
    assign item_slot   = SPAN_W'(item_diff);

    assign idx_is_last = (CNT_W'(idx_reg) + CNT_W'(1)) == item_count_reg;
    assign emit_en     = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
    assign pos         = cnt_rd_reg - CNT_W'(1);
    assign pfx_sum     = sum_reg + cnt_rd_reg;

    assign ib_we = accept && room;
    assign ib_re = (state_reg == S_H_RD) || (state_reg == S_W_RD);
    assign sb_we = (state_reg == S_W_WR);

    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_re    = 1'b0;
        cnt_waddr = span_idx_reg;
        cnt_raddr = item_slot;
        cnt_wdata = '0;
        case (state_reg)
            S_CLR_INIT, S_CLR_SET:
            begin
                cnt_we = 1'b1;
            end
            S_H_CNT, S_W_CNT:
            begin
                cnt_re = 1'b1;
            end
            S_H_WR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = slot_reg;
                cnt_wdata = cnt_rd_reg + CNT_W'(1);
            end
            S_PREFIX:
            begin
                cnt_re    = pfx_more_reg;
                cnt_raddr = span_idx_reg;
                cnt_we    = pend_reg;
                cnt_waddr = wr_slot_reg;
                cnt_wdata = pfx_sum;
            end
            S_W_WR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = slot_reg;
                cnt_wdata = pos;
            end
            default:
            begin
                cnt_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ib_we)
        begin
            ib_mem[item_count_reg[ITEM_W-1:0]] <= in_data.value;
        end
        if (ib_re)
        begin
            ib_rd_reg <= ib_mem[idx_reg];
        end
        if (emit_en)
        begin
            ib_emit_reg <= ib_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sb_we)
        begin
            sb_mem[pos[ITEM_W-1:0]] <= ib_rd_reg;
        end
        if (emit_en)
        begin
            sb_emit_reg <= sb_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rd_reg <= cnt_mem[cnt_raddr];
        end
    end

    assign cfg_write = psel && penable && pwrite
                    && (paddr[csort_pkg::PADDR_W-1:2] == csort_pkg::REG_MAX_SPREAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_spread_reg <= csort_pkg::SPREAD_RESET;
        end
        else if (cfg_write)
        begin
            max_spread_reg <= pwdata[csort_pkg::SPREAD_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[csort_pkg::PADDR_W-1:2] == csort_pkg::REG_MAX_SPREAD)
                  ? csort_pkg::PDATA_W'(max_spread_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLR_INIT;
            item_count_reg  <= '0;
            min_reg         <= '0;
            max_reg         <= '0;
            overflow_reg    <= 1'b0;
            idx_reg         <= '0;
            span_idx_reg    <= '0;
            spread_slot_reg <= '0;
            slot_reg        <= '0;
            wr_slot_reg     <= '0;
            sum_reg         <= '0;
            pend_reg        <= 1'b0;
            pfx_more_reg    <= 1'b0;
            status_reg      <= csort_pkg::STATUS_SORTED;
            wide_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= csort_pkg::STATUS_SORTED;
            out_end_reg     <= 1'b0;
            out_wide_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= emit_en || (out_valid_reg && out_stall);
            case (state_reg)
                S_CLR_INIT:
                begin
                    if (span_idx_reg == SPAN_W'(SPAN_DEPTH - 1))
                    begin
                        span_idx_reg <= '0;
                        state_reg    <= S_LOAD;
                    end
                    else
                    begin
                        span_idx_reg <= span_idx_reg + SPAN_W'(1);
                    end
                end
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (room)
                        begin
                            item_count_reg <= item_count_reg + CNT_W'(1);
                            if (item_count_reg == '0)
                            begin
                                min_reg <= in_data.value;
                                max_reg <= in_data.value;
                            end
                            else
                            begin
                                if (in_data.value < min_reg)
                                begin
                                    min_reg <= in_data.value;
                                end
                                if (in_data.value > max_reg)
                                begin
                                    max_reg <= in_data.value;
                                end
                            end
                        end
                        else
                        begin
                            overflow_reg <= 1'b1;
                        end
                        if (in_data.last)
                        begin
                            state_reg <= S_CHECK;
                        end
                    end
                end
                S_CHECK:
                begin
                    wide_reg        <= too_wide;
                    spread_slot_reg <= SPAN_W'(spread);
                    idx_reg         <= '0;
                    if (overflow_reg)
                    begin
                        status_reg <= csort_pkg::STATUS_DROPPED;
                    end
                    else if (too_wide)
                    begin
                        status_reg <= csort_pkg::STATUS_WIDE;
                    end
                    else
                    begin
                        status_reg <= csort_pkg::STATUS_SORTED;
                    end
                    state_reg <= too_wide ? S_EMIT : S_H_RD;
                end
                S_H_RD:
                begin
                    state_reg <= S_H_CNT;
                end
                S_H_CNT:
                begin
                    slot_reg  <= item_slot;
                    state_reg <= S_H_WR;
                end
                S_H_WR:
                begin
                    if (idx_is_last)
                    begin
                        span_idx_reg <= '0;
                        pfx_more_reg <= 1'b1;
                        pend_reg     <= 1'b0;
                        sum_reg      <= '0;
                        state_reg    <= S_PREFIX;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + ITEM_W'(1);
                        state_reg <= S_H_RD;
                    end
                end
                S_PREFIX:
                begin
                    if (pfx_more_reg)
                    begin
                        wr_slot_reg <= span_idx_reg;
                        pend_reg    <= 1'b1;
                        if (span_idx_reg == spread_slot_reg)
                        begin
                            pfx_more_reg <= 1'b0;
                        end
                        else
                        begin
                            span_idx_reg <= span_idx_reg + SPAN_W'(1);
                        end
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg)
                    begin
                        sum_reg <= pfx_sum;
                    end
                    if (pend_reg && !pfx_more_reg)
                    begin
                        idx_reg   <= ITEM_W'(item_count_reg - CNT_W'(1));
                        state_reg <= S_W_RD;
                    end
                end
                S_W_RD:
                begin
                    state_reg <= S_W_CNT;
                end
                S_W_CNT:
                begin
                    slot_reg  <= item_slot;
                    state_reg <= S_W_WR;
                end
                S_W_WR:
                begin
                    if (idx_reg == '0)
                    begin
                        span_idx_reg <= '0;
                        state_reg    <= S_CLR_SET;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg - ITEM_W'(1);
                        state_reg <= S_W_RD;
                    end
                end
                S_CLR_SET:
                begin
                    if (span_idx_reg == spread_slot_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        span_idx_reg <= span_idx_reg + SPAN_W'(1);
                    end
                end
                S_EMIT:
                begin
                    if (emit_en)
                    begin
                        out_status_reg <= status_reg;
                        out_end_reg    <= idx_is_last;
                        out_wide_reg   <= wide_reg;
                        if (idx_is_last)
                        begin
                            item_count_reg <= '0;
                            overflow_reg   <= 1'b0;
                            min_reg        <= '0;
                            max_reg        <= '0;
                            state_reg      <= S_LOAD;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + ITEM_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign out_valid             = out_valid_reg;
    assign out_data.sorted_value = out_wide_reg ? ib_emit_reg : sb_emit_reg;
    assign out_data.status       = out_status_reg;
    assign out_data.end_of_set   = out_end_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        item_count_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count exceeds buffer depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (item_count_reg != '0) |-> (min_reg <= max_reg))
        else $error("running minimum above running maximum");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_W_WR) |-> (cnt_rd_reg != '0))
        else $error("placement read an empty prefix count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (CNT_W'(idx_reg) < item_count_reg))
        else $error("emit index beyond stored items");

endmodule
